// ===== hw/rtl/video_chip_port_interface_assert.svh =====
// ----------------------------------------------------------------------------
// video_chip_port_interface_assert
// Assertion macros shared by the port interface modules.
// ----------------------------------------------------------------------------
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef VIDEO_CHIP_PORT_INTERFACE_ASSERT_SVH
`define VIDEO_CHIP_PORT_INTERFACE_ASSERT_SVH

// same-cycle implication
`define VCPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vcpi assertion failed");

// next-cycle implication
`define VCPI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vcpi assertion failed");

`endif

// ===== hw/rtl/vcpi_pkg.sv =====
// ----------------------------------------------------------------------------
// vcpi_pkg
// Types, codes and helpers shared by the video chip CPU port modules.
// ----------------------------------------------------------------------------
package vcpi_pkg;

  // video memory size
  localparam int unsigned VRAM_DEPTH_DEF = 16384;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // input opcodes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_CTRL_WRITE = 3'd1;
  localparam logic [2:0] OP_DATA_WRITE = 3'd2;
  localparam logic [2:0] OP_DATA_READ  = 3'd3;
  localparam logic [2:0] OP_STATUS     = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_LINE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = 2'd2;

  // configuration reset values and floors
  localparam logic [9:0] CYCLES_PER_LINE_RST = 10'd228;
  localparam logic [8:0] VBLANK_LINE_RST     = 9'd192;
  localparam logic [8:0] LINES_PER_FRAME_RST = 9'd262;
  localparam logic [9:0] CYCLES_PER_LINE_MIN = 10'd64;
  localparam logic [8:0] LINES_PER_FRAME_MIN = 9'd2;

  // second control byte actions (top two bits)
  localparam logic [1:0] CTRL_READ_ADDR = 2'b00;
  localparam logic [1:0] CTRL_REG_WRITE = 2'b10;

  // register indexes and bits that matter
  localparam logic [2:0] REG_MODE0 = 3'd0;
  localparam logic [2:0] REG_MODE1 = 3'd1;
  localparam int unsigned BIT_M3 = 1;
  localparam int unsigned BIT_IE = 5;
  localparam int unsigned BIT_M1 = 4;
  localparam int unsigned BIT_M2 = 3;

  // display modes
  localparam logic [1:0] MODE_GRAPHICS1 = 2'd0;
  localparam logic [1:0] MODE_GRAPHICS2 = 2'd1;
  localparam logic [1:0] MODE_TEXT      = 2'd2;
  localparam logic [1:0] MODE_MULTI     = 2'd3;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_CTRL,
    CMD_WRITE,
    CMD_READ,
    CMD_STATUS
  } cmd_kind_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_in;
    logic [5:0] elapsed_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       irq_line;
    logic [1:0] display_mode;
    logic [8:0] line_number;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic [5:0] cycles;
  } cmd_t;

  // why the front may not take a request
  typedef struct packed {
    logic q_full;
    logic clearing;
  } front_stall_t;

  // display mode from the three mode bits
  function automatic logic [1:0] mode_of(input logic m1, input logic m2, input logic m3);
    logic [1:0] m;
    m = MODE_GRAPHICS1;
    if (!m1 && !m2 && m3) m = MODE_GRAPHICS2;
    else if (m1 && !m2 && !m3) m = MODE_TEXT;
    else if (!m1 && m2 && !m3) m = MODE_MULTI;
    return m;
  endfunction

endpackage

// ===== hw/rtl/vcpi_front.sv =====
// ----------------------------------------------------------------------------
// vcpi_front
// Accepts CPU port requests and classifies them into queue commands.
// ----------------------------------------------------------------------------
module vcpi_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vcpi_pkg::in_item_t    in_data_i,
  input  vcpi_pkg::front_stall_t stall_i,
  output logic                  push_o,
  output vcpi_pkg::cmd_t        cmd_o
);
  import vcpi_pkg::*;

  cmd_kind_e kind;

  // take a request whenever the queue has room and memory is cleared
  assign in_ready_o = !stall_i.q_full && !stall_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  // opcode classification
  always_comb begin
    case (in_data_i.opcode)
      OP_TICK:       kind = CMD_TICK;
      OP_CTRL_WRITE: kind = CMD_CTRL;
      OP_DATA_WRITE: kind = CMD_WRITE;
      OP_DATA_READ:  kind = CMD_READ;
      OP_STATUS:     kind = CMD_STATUS;
      default:       kind = CMD_NOP;
    endcase
  end

  assign cmd_o.kind   = kind;
  assign cmd_o.data   = in_data_i.byte_in;
  assign cmd_o.cycles = in_data_i.elapsed_cycles;

endmodule

// ===== hw/rtl/vcpi_queue.sv =====
// ----------------------------------------------------------------------------
// vcpi_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`include "video_chip_port_interface_assert.svh"

module vcpi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vcpi_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output vcpi_pkg::cmd_t cmd_o
);
  import vcpi_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `VCPI_ASSERT_IMP(a_no_push_full, push_i, !full_o)
  `VCPI_ASSERT_IMP(a_no_pop_empty, pop_i, valid_o)
  `VCPI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_FULL)

endmodule

// ===== hw/rtl/vcpi_back.sv =====
// ----------------------------------------------------------------------------
// vcpi_back
// Executes queued commands: video memory, latch, registers, line timing.
// ----------------------------------------------------------------------------
`include "video_chip_port_interface_assert.svh"

module vcpi_back #(
  parameter int unsigned VRAM_DEPTH = vcpi_pkg::VRAM_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  vcpi_pkg::cmd_t                   q_cmd_i,
  output logic                             pop_o,
  output logic                             clearing_o,
  input  logic                             cfg_valid_i,
  input  logic [vcpi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vcpi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vcpi_pkg::out_item_t              out_data_o
);
  import vcpi_pkg::*;

  localparam int unsigned AW = $clog2(VRAM_DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(VRAM_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_LINE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    prefetch_q, prefetch_d;
  logic          vblank_q, vblank_d;
  logic          irq_q, irq_d;
  logic          latch_q, latch_d;
  logic [7:0]    held_q, held_d;
  logic [10:0]   cnt_q, cnt_d;
  logic [8:0]    line_q, line_d;
  logic          m1_q, m1_d, m2_q, m2_d, m3_q, m3_d, ie_q, ie_d;
  logic [9:0]    cpl_q;
  logic [8:0]    vbl_q, lpf_q;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_data_q, out_data_d;

  logic [7:0]    mem [VRAM_DEPTH];
  logic [7:0]    rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic          can_emit, pop, emit;
  logic [7:0]    byte_res;
  logic [9:0]    per_line;
  logic [8:0]    frame;
  logic [9:0]    line_inc;
  logic [AW-1:0] ctrl_addr;

  assign can_emit  = !out_valid_q || out_ready_i;
  assign pop       = (state_q == ST_IDLE) && q_valid_i && can_emit;
  assign pop_o     = pop;
  assign clearing_o = (state_q == ST_CLEAR);

  // effective timing limits
  assign per_line  = (cpl_q < CYCLES_PER_LINE_MIN) ? CYCLES_PER_LINE_MIN : cpl_q;
  assign frame     = (lpf_q < LINES_PER_FRAME_MIN) ? LINES_PER_FRAME_MIN : lpf_q;
  assign line_inc  = {1'b0, line_q} + 10'd1;
  assign ctrl_addr = AW'({q_cmd_i.data[5:0], held_q});

  // command execution
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    addr_d     = addr_q;
    prefetch_d = prefetch_q;
    vblank_d   = vblank_q;
    irq_d      = irq_q;
    latch_d    = latch_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    line_d     = line_q;
    m1_d       = m1_q;
    m2_d       = m2_q;
    m3_d       = m3_q;
    ie_d       = ie_q;
    we         = 1'b0;
    waddr      = addr_q;
    wdata      = q_cmd_i.data;
    raddr      = addr_q;
    emit       = 1'b0;
    byte_res   = 8'd0;

    case (state_q)
      ST_CLEAR: begin
        // zero one memory entry per cycle
        we    = 1'b1;
        waddr = clr_q;
        wdata = 8'd0;
        clr_d = clr_q + AW'(1);
        if (clr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd_i.kind)
            CMD_TICK: begin
              cnt_d   = cnt_q + 11'(q_cmd_i.cycles);
              state_d = ST_LINE;
            end
            CMD_CTRL: begin
              emit = 1'b1;
              if (!latch_q) begin
                held_d  = q_cmd_i.data;
                latch_d = 1'b1;
              end else begin
                latch_d = 1'b0;
                case (q_cmd_i.data[7:6])
                  CTRL_READ_ADDR: begin
                    raddr   = ctrl_addr;
                    addr_d  = ctrl_addr + AW'(1);
                    state_d = ST_READ;
                  end
                  CTRL_REG_WRITE: begin
                    if (q_cmd_i.data[2:0] == REG_MODE0) begin
                      m3_d = held_q[BIT_M3];
                    end
                    if (q_cmd_i.data[2:0] == REG_MODE1) begin
                      ie_d = held_q[BIT_IE];
                      m1_d = held_q[BIT_M1];
                      m2_d = held_q[BIT_M2];
                    end
                  end
                  default: begin
                    addr_d = ctrl_addr;
                  end
                endcase
              end
            end
            CMD_WRITE: begin
              emit       = 1'b1;
              we         = 1'b1;
              prefetch_d = q_cmd_i.data;
              addr_d     = addr_q + AW'(1);
              latch_d    = 1'b0;
            end
            CMD_READ: begin
              emit     = 1'b1;
              byte_res = prefetch_q;
              addr_d   = addr_q + AW'(1);
              latch_d  = 1'b0;
              state_d  = ST_READ;
            end
            CMD_STATUS: begin
              emit     = 1'b1;
              byte_res = {vblank_q, 7'd0};
              vblank_d = 1'b0;
              irq_d    = 1'b0;
              latch_d  = 1'b0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // memory data arrives, refill the read buffer
        prefetch_d = rdata_q;
        state_d    = ST_IDLE;
      end
      ST_LINE: begin
        // one scanline per cycle until the count is below the line length
        if (cnt_q >= {1'b0, per_line}) begin
          cnt_d = cnt_q - {1'b0, per_line};
          if (line_inc == {1'b0, vbl_q}) begin
            vblank_d = 1'b1;
            if (ie_q) begin
              irq_d = 1'b1;
            end
          end
          if (line_inc >= {1'b0, frame}) begin
            line_d = 9'd0;
          end else begin
            line_d = line_inc[8:0];
          end
        end else begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d             = 1'b1;
      out_data_d.byte_out     = byte_res;
      out_data_d.irq_line     = irq_d;
      out_data_d.display_mode = mode_of(m1_d, m2_d, m3_d);
      out_data_d.line_number  = line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      addr_q      <= '0;
      prefetch_q  <= 8'd0;
      vblank_q    <= 1'b0;
      irq_q       <= 1'b0;
      latch_q     <= 1'b0;
      held_q      <= 8'd0;
      cnt_q       <= 11'd0;
      line_q      <= 9'd0;
      m1_q        <= 1'b0;
      m2_q        <= 1'b0;
      m3_q        <= 1'b0;
      ie_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      addr_q      <= addr_d;
      prefetch_q  <= prefetch_d;
      vblank_q    <= vblank_d;
      irq_q       <= irq_d;
      latch_q     <= latch_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      line_q      <= line_d;
      m1_q        <= m1_d;
      m2_q        <= m2_d;
      m3_q        <= m3_d;
      ie_q        <= ie_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q <= CYCLES_PER_LINE_RST;
      vbl_q <= VBLANK_LINE_RST;
      lpf_q <= LINES_PER_FRAME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CYCLES_PER_LINE: cpl_q <= cfg_data_i;
        CFG_VBLANK_LINE:     vbl_q <= cfg_data_i[8:0];
        CFG_LINES_PER_FRAME: lpf_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // video memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `VCPI_ASSERT_IMP(a_no_pop_in_clear, state_q == ST_CLEAR, !pop)
  `VCPI_ASSERT_IMP(a_emit_has_room, emit, can_emit)
  `VCPI_ASSERT_NXT(a_read_one_cycle, state_q == ST_READ, state_q == ST_IDLE)
  `VCPI_ASSERT_NXT(a_line_loop_ends, (state_q == ST_LINE) && (cnt_q < {1'b0, per_line}),
                   (state_q == ST_IDLE) && out_valid_q)
  `VCPI_ASSERT_IMP(a_line_in_range, 1'b1, line_q != 9'h1FF)

endmodule

// ===== hw/rtl/video_chip_port_interface.sv =====
// ----------------------------------------------------------------------------
// video_chip_port_interface
// CPU side port of a tile video chip: latch, registers, memory, line timing.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one request per handshake (tick, control write, data write,
//                 data read, status read); unknown opcodes change nothing.
//   out channel : exactly one result per request, in request order.
//   cfg channel : line length, vblank line, lines per frame; always ready,
//                 write only while no request is in flight.
//   Reset clears all state, then a clearing pass zeroes every entry of the
//   video memory, one entry per cycle; in_ready_o stays low during the pass,
//   configuration writes are still taken.
//   Path: with the back idle a request passes the queue and then the result
//   register on its way to out_valid_o. Pacing: control, write and status
//   requests leave the back idle for the next request; data reads and
//   read-address setup first pass through the read state, where the registered
//   memory read refills the read buffer; ticks hold the back in the line state
//   while the one-line-per-cycle counter counts off the scanlines crossed.
//   A two-entry queue keeps taking requests while the result register waits
//   on a stalled receiver; when the queue is full in_ready_o drops.
// ----------------------------------------------------------------------------
module video_chip_port_interface #(
  parameter int unsigned VRAM_DEPTH = vcpi_pkg::VRAM_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vcpi_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vcpi_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vcpi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vcpi_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vcpi_pkg::*;

  front_stall_t stall;
  logic         push, pop, q_full, q_valid, clearing;
  cmd_t         push_cmd, head_cmd;

  assign cfg_ready_o    = 1'b1;
  assign stall.q_full   = q_full;
  assign stall.clearing = clearing;

  // request intake and classification
  vcpi_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .stall_i    (stall),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue
  vcpi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // execution
  vcpi_back #(
    .VRAM_DEPTH (VRAM_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video chip port interface testbench
// Sends CPU port requests (ticks, control and data writes, data and status
// reads) through the valid/ready input channel. Each accepted request is run
// through an in-house model of the port, and the result is queued. Results
// from the block are checked field by field, in order. Several line timing
// settings are applied between phases, and both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import vcpi_pkg::*;

  // opcodes the block ignores, control actions not named in the package
  localparam logic [2:0] OP_SPARE_FIRST      = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST       = 3'd7;
  localparam logic [1:0] CTRL_WRITE_ADDR     = 2'b01;
  localparam logic [1:0] CTRL_WRITE_ADDR_ALT = 2'b11;
  localparam logic [7:0] STATUS_VBLANK       = 8'h80;

  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT    = 300000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  video_chip_port_interface u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // port model state
  logic [7:0]  vram_image [VRAM_DEPTH_DEF];
  logic [7:0]  vreg [8];
  logic [13:0] vaddr;
  logic [7:0]  read_buf;
  logic [7:0]  status_q;
  bit          latch_set;
  logic [7:0]  latch_byte;
  int unsigned line_cycles;
  int unsigned scanline;
  bit          irq_q;
  logic [1:0]  mode_q;
  logic [9:0]  timing_cpl;
  logic [8:0]  timing_vbl;
  logic [8:0]  timing_lpf;

  // request and result stores
  in_item_t    cpu_requests [$];
  out_item_t   port_results [$];
  out_item_t   oldest;

  int unsigned queued_items;
  int unsigned fail_count;
  int unsigned tb_cycles;
  int unsigned send_gap;
  int unsigned rx_stall;
  bit          req_taken;
  bit          cfg_taken;
  bit          drain_req;
  bit          rx_hold_req;
  bit          quiet;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model of one request, returns the port's result
  function automatic out_item_t port_step(in_item_t req);
    out_item_t   res;
    int unsigned per_line;
    int unsigned frame;
    logic [13:0] target;
    res = '0;
    case (req.opcode)
      OP_TICK: begin
        per_line = 32'((timing_cpl < CYCLES_PER_LINE_MIN) ? CYCLES_PER_LINE_MIN : timing_cpl);
        frame = 32'((timing_lpf < LINES_PER_FRAME_MIN) ? LINES_PER_FRAME_MIN : timing_lpf);
        line_cycles += req.elapsed_cycles;
        while (line_cycles >= per_line) begin
          line_cycles -= per_line;
          scanline++;
          // vblank compare comes before the frame wrap
          if (scanline == timing_vbl) begin
            status_q = status_q | STATUS_VBLANK;
            if (vreg[REG_MODE1][BIT_IE]) irq_q = 1'b1;
          end
          if (scanline >= frame) scanline = 0;
        end
      end
      OP_CTRL_WRITE: begin
        if (!latch_set) begin
          latch_byte = req.byte_in;
          latch_set = 1'b1;
        end else begin
          latch_set = 1'b0;
          target = {req.byte_in[5:0], latch_byte};
          case (req.byte_in[7:6])
            CTRL_READ_ADDR: begin
              read_buf = vram_image[target];
              vaddr = target + 14'd1;
            end
            CTRL_REG_WRITE: begin
              vreg[req.byte_in[2:0]] = latch_byte;
              // exactly one mode bit picks a mode, anything else is graphics one
              case ({vreg[REG_MODE1][BIT_M1], vreg[REG_MODE1][BIT_M2],
                     vreg[REG_MODE0][BIT_M3]})
                3'b001:  mode_q = MODE_GRAPHICS2;
                3'b100:  mode_q = MODE_TEXT;
                3'b010:  mode_q = MODE_MULTI;
                default: mode_q = MODE_GRAPHICS1;
              endcase
            end
            default: vaddr = target;
          endcase
        end
      end
      OP_DATA_WRITE: begin
        vram_image[vaddr] = req.byte_in;
        read_buf = req.byte_in;
        vaddr = vaddr + 14'd1;
        latch_set = 1'b0;
      end
      OP_DATA_READ: begin
        res.byte_out = read_buf;
        read_buf = vram_image[vaddr];
        vaddr = vaddr + 14'd1;
        latch_set = 1'b0;
      end
      OP_STATUS: begin
        res.byte_out = status_q;
        status_q = '0;
        irq_q = 1'b0;
        latch_set = 1'b0;
      end
      default: ;
    endcase
    res.irq_line = irq_q;
    res.display_mode = mode_q;
    res.line_number = scanline[8:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void queue_req(logic [2:0] op, logic [7:0] data, logic [5:0] cycles);
    in_item_t req;
    req.opcode = op;
    req.byte_in = data;
    req.elapsed_cycles = cycles;
    cpu_requests.push_back(req);
    if (op <= OP_STATUS) queued_items++;
  endfunction

  // mostly a small window so reads find earlier writes
  function automatic logic [13:0] pick_addr();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 14'h3FFF;
    if (roll < 75) return 14'($urandom_range(0, 31));
    return 14'($urandom);
  endfunction

  // cycle limit
  always @(posedge clk_i) begin
    tb_cycles++;
    if (tb_cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // monitor: results, then config writes and new requests
  always @(posedge clk_i) begin
    req_taken <= in_valid_i && in_ready_o;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (port_results.size() == 0) begin
          $error("result with no request waiting: %h", out_data_o);
          fail_count++;
        end else begin
          oldest = port_results.pop_front();
          check_field("byte_out", 9'(oldest.byte_out), 9'(out_data_o.byte_out));
          check_field("irq_line", 9'(oldest.irq_line), 9'(out_data_o.irq_line));
          check_field("display_mode", 9'(oldest.display_mode),
                      9'(out_data_o.display_mode));
          check_field("line_number", oldest.line_number, out_data_o.line_number);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CYCLES_PER_LINE: timing_cpl = cfg_data_i;
          CFG_VBLANK_LINE:     timing_vbl = cfg_data_i[8:0];
          CFG_LINES_PER_FRAME: timing_lpf = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) port_results.push_back(port_step(in_data_i));
    end
  end

  // driver: offers queued requests with random gaps
  always @(negedge clk_i) begin
    if (in_valid_i && !req_taken) begin
      // request still waiting, hold it
    end else begin
      if (in_valid_i && !quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 8);
      if (drain_req && port_results.size() == 0) drain_req = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!drain_req && cpu_requests.size() != 0) begin
        in_data_i <= cpu_requests.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts and one long hold
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall = RX_HOLD_CYCLES;
    end else if (rx_stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(1, 8);
    end
    if (rx_stall != 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_timing(logic [9:0] cpl, logic [9:0] vbl, logic [9:0] lpf);
    write_reg(CFG_CYCLES_PER_LINE, cpl);
    write_reg(CFG_VBLANK_LINE, vbl);
    write_reg(CFG_LINES_PER_FRAME, lpf);
  endtask

  // random request sequences, mostly well formed
  task automatic fill_random(int unsigned n_items);
    int unsigned roll;
    int unsigned run;
    logic [13:0] addr;
    logic [2:0]  idx;
    queued_items = 0;
    while (queued_items < n_items) begin
      roll = $urandom_range(0, 99);
      run = $urandom_range(1, 6);
      if (roll < 25) begin
        // set write address, then a run of data writes
        addr = pick_addr();
        queue_req(OP_CTRL_WRITE, addr[7:0], 6'($urandom));
        queue_req(OP_CTRL_WRITE, {($urandom_range(0, 1) ? CTRL_WRITE_ADDR : CTRL_WRITE_ADDR_ALT),
                                  addr[13:8]}, 6'($urandom));
        repeat (run) queue_req(OP_DATA_WRITE, 8'($urandom), 6'($urandom));
      end else if (roll < 45) begin
        // set read address, then a run of data reads
        addr = pick_addr();
        queue_req(OP_CTRL_WRITE, addr[7:0], 6'($urandom));
        queue_req(OP_CTRL_WRITE, {CTRL_READ_ADDR, addr[13:8]}, 6'($urandom));
        repeat (run) queue_req(OP_DATA_READ, 8'($urandom), 6'($urandom));
      end else if (roll < 58) begin
        // register write, mostly the mode registers
        idx = $urandom_range(0, 1) ? 3'($urandom_range(REG_MODE0, REG_MODE1))
                                   : 3'($urandom);
        queue_req(OP_CTRL_WRITE, 8'($urandom), 6'($urandom));
        queue_req(OP_CTRL_WRITE, {CTRL_REG_WRITE, 3'($urandom), idx}, 6'($urandom));
      end else if (roll < 78) begin
        repeat ($urandom_range(1, 4)) queue_req(OP_TICK, 8'($urandom), 6'($urandom));
      end else if (roll < 88) begin
        queue_req(OP_STATUS, 8'($urandom), 6'($urandom));
      end else if (roll < 93) begin
        // broken pair: lone control byte, then a latch clearing access
        queue_req(OP_CTRL_WRITE, 8'($urandom), 6'($urandom));
        queue_req(3'($urandom_range(OP_DATA_WRITE, OP_STATUS)), 8'($urandom), 6'($urandom));
      end else if (roll < 96) begin
        queue_req(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 8'($urandom),
                  6'($urandom));
      end else begin
        queue_req(3'($urandom), 8'($urandom), 6'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (cpu_requests.size() != 0 || in_valid_i || port_results.size() != 0);
  endtask

  initial begin
    int unsigned start_size;
    foreach (vram_image[i]) vram_image[i] = '0;
    foreach (vreg[i]) vreg[i] = '0;
    vaddr = '0;
    read_buf = '0;
    status_q = '0;
    latch_set = 1'b0;
    latch_byte = '0;
    line_cycles = 0;
    scanline = 0;
    irq_q = 1'b0;
    mode_q = MODE_GRAPHICS1;
    timing_cpl = CYCLES_PER_LINE_RST;
    timing_vbl = VBLANK_LINE_RST;
    timing_lpf = LINES_PER_FRAME_RST;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // short frame with an early vblank, written during the clearing pass
    set_timing(10'd64, 10'd3, 10'd6);
    queue_req(OP_STATUS, 8'h00, 6'h00);
    queue_req(OP_SPARE_FIRST, 8'hFF, 6'h3F);
    // register 1: interrupt enable and text mode
    queue_req(OP_CTRL_WRITE, 8'h30, 6'h00);
    queue_req(OP_CTRL_WRITE, {CTRL_REG_WRITE, 3'b000, REG_MODE1}, 6'h00);
    // register 0 mode bit on top of it: mixed bits give graphics one
    queue_req(OP_CTRL_WRITE, 8'h02, 6'h00);
    queue_req(OP_CTRL_WRITE, {CTRL_REG_WRITE, 3'b000, REG_MODE0}, 6'h00);
    // write at the top address, then wrap to zero
    queue_req(OP_CTRL_WRITE, 8'hFF, 6'h00);
    queue_req(OP_CTRL_WRITE, {CTRL_WRITE_ADDR, 6'h3F}, 6'h00);
    queue_req(OP_DATA_WRITE, 8'hA5, 6'h00);
    queue_req(OP_DATA_WRITE, 8'h5A, 6'h00);
    // read back across the wrap
    queue_req(OP_CTRL_WRITE, 8'hFF, 6'h00);
    queue_req(OP_CTRL_WRITE, {CTRL_READ_ADDR, 6'h3F}, 6'h00);
    queue_req(OP_DATA_READ, 8'h00, 6'h00);
    queue_req(OP_DATA_READ, 8'h00, 6'h00);
    // a data read empties the latch, then the alternate write address code
    queue_req(OP_CTRL_WRITE, 8'h12, 6'h00);
    queue_req(OP_DATA_READ, 8'h00, 6'h00);
    queue_req(OP_CTRL_WRITE, 8'h00, 6'h00);
    queue_req(OP_CTRL_WRITE, {CTRL_WRITE_ADDR_ALT, 6'h00}, 6'h00);
    // run up to the vblank line
    repeat (4) queue_req(OP_TICK, 8'h00, 6'h3F);
    // dropping interrupt enable leaves the pending interrupt alone
    queue_req(OP_CTRL_WRITE, 8'h00, 6'h00);
    queue_req(OP_CTRL_WRITE, {CTRL_REG_WRITE, 3'b000, REG_MODE1}, 6'h00);
    queue_req(OP_TICK, 8'h00, 6'h00);
    queue_req(OP_STATUS, 8'h00, 6'h00);
    fill_random(60);
    wait_idle();

    // longest line, vblank on the first line, shortest frame
    set_timing(10'd1023, 10'd1, 10'd2);
    fill_random(50);
    wait_idle();

    // line length and frame below their floors, vblank disabled
    set_timing(10'd10, 10'd0, 10'd1);
    fill_random(50);
    wait_idle();

    // vblank past the end of the frame is never reached
    set_timing(10'd64, 10'd9, 10'd5);
    fill_random(40);
    wait_idle();

    // largest vblank line and frame
    set_timing(10'd64, 10'd511, 10'd511);
    fill_random(40);
    wait_idle();

    // random small timing, with a long receiver hold and a sender drain
    set_timing(10'($urandom_range(64, 160)), 10'($urandom_range(1, 12)),
               10'($urandom_range(2, 16)));
    fill_random(90);
    start_size = cpu_requests.size();
    do @(posedge clk_i); while (cpu_requests.size() > start_size - 8);
    rx_hold_req = 1'b1;
    do @(posedge clk_i); while (cpu_requests.size() > start_size - 40);
    drain_req = 1'b1;
    wait_idle();

    // last stretch runs at full rate on both sides
    quiet = 1'b1;
    set_timing(10'd100, 10'd4, 10'd12);
    fill_random(100);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== video_chip_port_interface.f =====
+incdir+hw/rtl
hw/rtl/vcpi_pkg.sv
hw/rtl/vcpi_front.sv
hw/rtl/vcpi_queue.sv
hw/rtl/vcpi_back.sv
hw/rtl/video_chip_port_interface.sv
tb/sv/testbench.sv
